// ----- rtl/shl2d_pkg.sv -----
package shl2d_pkg;

    // Defaults for the top level parameters
    localparam int BINS_PER_AXIS_DEF = 256;
    localparam int COUNT_WIDTH_DEF   = 32;

    // Widest bin address over the parameter range (4096 * 4096 bins)
    localparam int ADDR_W_MAX = 24;

    // Input item kinds
    localparam logic [1:0] KIND_ACC   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

    // log10 datapath
    localparam int          MANT_W      = 31;          // Q1.30 mantissa
    localparam int          FRAC_BITS   = 20;          // log2 fraction bits
    localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;
    localparam int          LOG_SHIFT   = 40;          // Q.20 * Q.32 -> Q.12
    localparam int          LOG_W       = 16;

    // Scale steps in Q4.12
    localparam logic [11:0] HALF_Q12 = 12'h800;
    localparam logic [15:0] ONE_Q12  = 16'h1000;

    typedef struct packed {
        logic [1:0]            op;
        logic [ADDR_W_MAX-1:0] addr;
    } cmd_t;

endpackage

// ----- rtl/shl2d_front.sv -----
module shl2d_front #(
    parameter int BINS_PER_AXIS = shl2d_pkg::BINS_PER_AXIS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic signed [23:0]  cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_kind,
    input  logic signed [23:0]  s_x_value,
    input  logic signed [23:0]  s_y_value,
    input  logic [7:0]          s_read_row,
    input  logic [7:0]          s_read_col,
    input  logic                clearing,
    input  logic                push_ready,
    output logic                push_valid,
    output shl2d_pkg::cmd_t     push_cmd
);

    localparam int AW  = $clog2(BINS_PER_AXIS);
    localparam int DAW = $clog2(BINS_PER_AXIS * BINS_PER_AXIS);

    logic signed [23:0] thr_reg;
    logic signed [23:0] thr_next;

    logic [AW-1:0]  col;
    logic [AW-1:0]  row;
    logic [AW-1:0]  x_bin;
    logic [AW-1:0]  y_bin;
    logic [AW-1:0]  rd_row;
    logic [AW-1:0]  rd_col;
    logic [DAW-1:0] addr;
    logic           keep;
    logic           in_range;

    assign cfg_ready = 1'b1;
    assign thr_next  = (cfg_valid && cfg_ready) ? cfg_data : thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= 24'sh7FFFFF;
        end else begin
            thr_reg <= thr_next;
        end
    end

    // floor of Q16.8 is the integer part; clamp to the bin range
    always_comb begin
        if (s_x_value[23]) begin
            x_bin = '0;
        end else if (s_x_value[22:8] > 15'(BINS_PER_AXIS - 1)) begin
            x_bin = AW'(BINS_PER_AXIS - 1);
        end else begin
            x_bin = AW'(s_x_value[22:8]);
        end
        if (s_y_value[23]) begin
            y_bin = '0;
        end else if (s_y_value[22:8] > 15'(BINS_PER_AXIS - 1)) begin
            y_bin = AW'(BINS_PER_AXIS - 1);
        end else begin
            y_bin = AW'(s_y_value[22:8]);
        end
        if ({5'd0, s_read_row} > 13'(BINS_PER_AXIS - 1)) begin
            rd_row = AW'(BINS_PER_AXIS - 1);
        end else begin
            rd_row = AW'(s_read_row);
        end
        if ({5'd0, s_read_col} > 13'(BINS_PER_AXIS - 1)) begin
            rd_col = AW'(BINS_PER_AXIS - 1);
        end else begin
            rd_col = AW'(s_read_col);
        end
    end

    assign in_range = (s_x_value < thr_reg) && (s_y_value < thr_reg);

    always_comb begin
        keep = 1'b0;
        row  = rd_row;
        col  = rd_col;
        case (s_kind)
            shl2d_pkg::KIND_ACC: begin
                keep = in_range;
                row  = y_bin;
                col  = x_bin;
            end
            shl2d_pkg::KIND_READ: begin
                keep = 1'b1;
            end
            shl2d_pkg::KIND_CLEAR: begin
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign addr    = DAW'(row) * DAW'(BINS_PER_AXIS) + DAW'(col);
    assign s_ready = push_ready && !clearing;

    assign push_valid    = s_valid && s_ready && keep;
    assign push_cmd.op   = s_kind;
    assign push_cmd.addr = shl2d_pkg::ADDR_W_MAX'(addr);

endmodule

// ----- rtl/shl2d_queue.sv -----
module shl2d_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  shl2d_pkg::cmd_t push_cmd,
    output logic            pop_valid,
    input  logic            pop,
    output shl2d_pkg::cmd_t pop_cmd
);

    localparam int PW = shl2d_pkg::QUEUE_PW;
    localparam int CW = $clog2(shl2d_pkg::QUEUE_DEPTH + 1);

    shl2d_pkg::cmd_t slot_reg [shl2d_pkg::QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = fill_reg != CW'(shl2d_pkg::QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/shl2d_log.sv -----
module shl2d_log #(
    parameter int COUNT_WIDTH = shl2d_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [COUNT_WIDTH-1:0]       value,
    output logic                         done,
    output logic [shl2d_pkg::LOG_W-1:0]  result
);

    localparam int MW = shl2d_pkg::MANT_W;
    localparam int FB = shl2d_pkg::FRAC_BITS;
    localparam int NW = (COUNT_WIDTH > MW) ? COUNT_WIDTH : MW;
    localparam int SW = $clog2(NW);
    localparam int KW = $clog2(SW);
    localparam int IW = $clog2(FB);
    localparam int LW = SW + FB;
    localparam int PW = LW + 32;

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_NORM = 3'd1;
    localparam logic [2:0] L_LOAD = 3'd2;
    localparam logic [2:0] L_SQ   = 3'd3;
    localparam logic [2:0] L_MUL  = 3'd4;
    localparam logic [2:0] L_DONE = 3'd5;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [NW-1:0]               norm_reg;
    logic [NW-1:0]               norm_next;
    logic [SW-1:0]               sh_reg;
    logic [SW-1:0]               sh_next;
    logic [KW-1:0]               k_reg;
    logic [KW-1:0]               k_next;
    logic [MW-1:0]               m_reg;
    logic [MW-1:0]               m_next;
    logic [SW-1:0]               e_reg;
    logic [SW-1:0]               e_next;
    logic [FB-1:0]               frac_reg;
    logic [FB-1:0]               frac_next;
    logic [IW-1:0]               iter_reg;
    logic [IW-1:0]               iter_next;
    logic [PW-1:0]               prod_reg;
    logic [PW-1:0]               prod_next;
    logic [shl2d_pkg::LOG_W-1:0] res_reg;
    logic [shl2d_pkg::LOG_W-1:0] res_next;
    logic                        done_reg;
    logic                        done_next;

    logic [SW-1:0]   step;
    logic [SW:0]     top_sh;
    logic            top_zero;
    logic [2*MW-1:0] sq;
    logic [MW:0]     sq_top;
    logic [MW-1:0]   m_sq;

    assign done   = done_reg;
    assign result = res_reg;

    // one binary normalization step per cycle
    assign step     = SW'(1) << k_reg;
    assign top_sh   = (SW + 1)'(NW) - (SW + 1)'(step);
    assign top_zero = (norm_reg >> top_sh) == '0;

    // square of Q1.30 mantissa, back to Q.30
    assign sq     = (2 * MW)'(m_reg) * (2 * MW)'(m_reg);
    assign sq_top = sq[2*MW-1:MW-1];
    assign m_sq   = sq_top[MW] ? sq_top[MW:1] : sq_top[MW-1:0];

    always_comb begin
        state_next = state_reg;
        norm_next  = norm_reg;
        sh_next    = sh_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        e_next     = e_reg;
        frac_next  = frac_reg;
        iter_next  = iter_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        case (state_reg)
            L_IDLE: begin
                if (start) begin
                    if ((value >> 1) == '0) begin
                        res_next  = '0;
                        done_next = 1'b1;
                    end else begin
                        norm_next  = NW'(value);
                        sh_next    = '0;
                        k_next     = KW'(SW - 1);
                        state_next = L_NORM;
                    end
                end
            end
            L_NORM: begin
                if (top_zero) begin
                    norm_next = norm_reg << step;
                    sh_next   = sh_reg + step;
                end
                if (k_reg == '0) begin
                    state_next = L_LOAD;
                end else begin
                    k_next = k_reg - KW'(1);
                end
            end
            L_LOAD: begin
                m_next     = norm_reg[NW-1 -: MW];
                e_next     = SW'(NW - 1) - sh_reg;
                frac_next  = '0;
                iter_next  = '0;
                state_next = L_SQ;
            end
            L_SQ: begin
                m_next    = m_sq;
                frac_next = {frac_reg[FB-2:0], sq_top[MW]};
                if (iter_reg == IW'(FB - 1)) begin
                    state_next = L_MUL;
                end else begin
                    iter_next = iter_reg + IW'(1);
                end
            end
            L_MUL: begin
                prod_next  = PW'({e_reg, frac_reg}) * PW'(shl2d_pkg::LOG10_2_Q32);
                state_next = L_DONE;
            end
            L_DONE: begin
                res_next   = prod_reg[shl2d_pkg::LOG_SHIFT +: shl2d_pkg::LOG_W];
                done_next  = 1'b1;
                state_next = L_IDLE;
            end
            default: begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        norm_reg <= norm_next;
        sh_reg   <= sh_next;
        k_reg    <= k_next;
        m_reg    <= m_next;
        e_reg    <= e_next;
        frac_reg <= frac_next;
        iter_reg <= iter_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

endmodule

// ----- rtl/shl2d_back.sv -----
module shl2d_back #(
    parameter int BINS_PER_AXIS = shl2d_pkg::BINS_PER_AXIS_DEF,
    parameter int COUNT_WIDTH   = shl2d_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  shl2d_pkg::cmd_t              q_cmd,
    output logic                         q_pop,
    output logic                         clearing,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [31:0]                  m_bin_count,
    output logic [shl2d_pkg::LOG_W-1:0]  m_bin_log,
    output logic [shl2d_pkg::LOG_W-1:0]  m_max_log,
    output logic [shl2d_pkg::LOG_W-1:0]  m_scale_top
);

    localparam int DEPTH = BINS_PER_AXIS * BINS_PER_AXIS;
    localparam int DAW   = $clog2(DEPTH);
    localparam int LGW   = shl2d_pkg::LOG_W;

    localparam logic [3:0] B_CLR     = 4'd0;
    localparam logic [3:0] B_IDLE    = 4'd1;
    localparam logic [3:0] B_ACC_RD  = 4'd2;
    localparam logic [3:0] B_ACC_WR  = 4'd3;
    localparam logic [3:0] B_RD_RD   = 4'd4;
    localparam logic [3:0] B_RD_CAP  = 4'd5;
    localparam logic [3:0] B_LOG_BIN = 4'd6;
    localparam logic [3:0] B_LOG_MAX = 4'd7;
    localparam logic [3:0] B_OUT     = 4'd8;

    logic [COUNT_WIDTH-1:0] bin_mem [DEPTH];

    logic [3:0]             state_reg;
    logic [3:0]             state_next;
    logic [DAW-1:0]         addr_reg;
    logic [DAW-1:0]         addr_next;
    logic [COUNT_WIDTH-1:0] rdata_reg;
    logic [COUNT_WIDTH-1:0] largest_reg;
    logic [COUNT_WIDTH-1:0] largest_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [LGW-1:0]         bin_log_reg;
    logic [LGW-1:0]         bin_log_next;
    logic [LGW-1:0]         max_log_reg;
    logic [LGW-1:0]         max_log_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [31:0]            m_count_reg;
    logic [31:0]            m_count_next;
    logic [LGW-1:0]         m_bin_log_reg;
    logic [LGW-1:0]         m_bin_log_next;
    logic [LGW-1:0]         m_max_log_reg;
    logic [LGW-1:0]         m_max_log_next;
    logic [LGW-1:0]         m_top_reg;
    logic [LGW-1:0]         m_top_next;

    logic [COUNT_WIDTH-1:0] inc;
    logic                   mem_we;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic                   log_start;
    logic [COUNT_WIDTH-1:0] log_value;
    logic                   log_done;
    logic [LGW-1:0]         log_result;
    logic [63:0]            count_ext;
    logic [31:0]            count_sat;
    logic [LGW-1:0]         scale_top;

    shl2d_log #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (log_start),
        .value   (log_value),
        .done    (log_done),
        .result  (log_result)
    );

    assign clearing    = state_reg == B_CLR;
    assign m_valid     = m_valid_reg;
    assign m_bin_count = m_count_reg;
    assign m_bin_log   = m_bin_log_reg;
    assign m_max_log   = m_max_log_reg;
    assign m_scale_top = m_top_reg;

    // saturating increment of the bin just read
    assign inc       = (rdata_reg == '1) ? rdata_reg : rdata_reg + COUNT_WIDTH'(1);
    assign mem_wdata = (state_reg == B_CLR) ? '0 : inc;

    assign count_ext = 64'(count_reg);
    assign count_sat = (count_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : count_ext[31:0];

    // next half step above max_log
    assign scale_top = (max_log_reg[11:0] < shl2d_pkg::HALF_Q12)
                     ? {max_log_reg[15:12], shl2d_pkg::HALF_Q12}
                     : {max_log_reg[15:12], 12'h000} + shl2d_pkg::ONE_Q12;

    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        largest_next   = largest_reg;
        count_next     = count_reg;
        bin_log_next   = bin_log_reg;
        max_log_next   = max_log_reg;
        m_valid_next   = m_valid_reg;
        m_count_next   = m_count_reg;
        m_bin_log_next = m_bin_log_reg;
        m_max_log_next = m_max_log_reg;
        m_top_next     = m_top_reg;
        mem_we         = 1'b0;
        log_start      = 1'b0;
        log_value      = rdata_reg;
        q_pop          = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            B_CLR: begin
                mem_we = 1'b1;
                if (addr_reg == DAW'(DEPTH - 1)) begin
                    state_next = B_IDLE;
                end else begin
                    addr_next = addr_reg + DAW'(1);
                end
            end
            B_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_cmd.op)
                        shl2d_pkg::KIND_ACC: begin
                            addr_next  = q_cmd.addr[DAW-1:0];
                            state_next = B_ACC_RD;
                        end
                        shl2d_pkg::KIND_READ: begin
                            addr_next  = q_cmd.addr[DAW-1:0];
                            state_next = B_RD_RD;
                        end
                        shl2d_pkg::KIND_CLEAR: begin
                            addr_next    = '0;
                            largest_next = '0;
                            state_next   = B_CLR;
                        end
                        default: begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_ACC_RD: begin
                state_next = B_ACC_WR;
            end
            B_ACC_WR: begin
                mem_we = 1'b1;
                if (inc > largest_reg) begin
                    largest_next = inc;
                end
                state_next = B_IDLE;
            end
            B_RD_RD: begin
                state_next = B_RD_CAP;
            end
            B_RD_CAP: begin
                count_next = rdata_reg;
                log_start  = 1'b1;
                state_next = B_LOG_BIN;
            end
            B_LOG_BIN: begin
                log_value = largest_reg;
                if (log_done) begin
                    bin_log_next = log_result;
                    log_start    = 1'b1;
                    state_next   = B_LOG_MAX;
                end
            end
            B_LOG_MAX: begin
                if (log_done) begin
                    max_log_next = log_result;
                    state_next   = B_OUT;
                end
            end
            B_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_count_next   = count_sat;
                    m_bin_log_next = bin_log_reg;
                    m_max_log_next = max_log_reg;
                    m_top_next     = scale_top;
                    state_next     = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLR;
            addr_reg    <= '0;
            largest_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            largest_reg <= largest_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg     <= count_next;
        bin_log_reg   <= bin_log_next;
        max_log_reg   <= max_log_next;
        m_count_reg   <= m_count_next;
        m_bin_log_reg <= m_bin_log_next;
        m_max_log_reg <= m_max_log_next;
        m_top_reg     <= m_top_next;
    end

    // bin store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bin_mem[addr_reg] <= mem_wdata;
        end
        rdata_reg <= bin_mem[addr_reg];
    end

endmodule

// ----- rtl/scatter_histogram_2d_log_core.sv -----
// Accumulate: into the command queue, then the bin store loop pops it, reads the bin and writes it back.
// Read: the bin store read, then two passes through the shared log10 unit (20 squaring
//   steps each), one for the bin count and one for the largest count.
// Clear: all BINS_PER_AXIS^2 bins, one bin zeroed per cycle through the store write port.
// Reset (aresetn low, synchronous) clears control state and then runs the same clearing
//   pass; s_ready stays low until it ends.
module scatter_histogram_2d_log_core #(
    parameter int BINS_PER_AXIS = shl2d_pkg::BINS_PER_AXIS_DEF,
    parameter int COUNT_WIDTH   = shl2d_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // null threshold write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic signed [23:0]           cfg_data,
    // item input
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_kind,
    input  logic signed [23:0]           s_x_value,
    input  logic signed [23:0]           s_y_value,
    input  logic [7:0]                   s_read_row,
    input  logic [7:0]                   s_read_col,
    // read results
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [31:0]                  m_bin_count,
    output logic [shl2d_pkg::LOG_W-1:0]  m_bin_log,
    output logic [shl2d_pkg::LOG_W-1:0]  m_max_log,
    output logic [shl2d_pkg::LOG_W-1:0]  m_scale_top
);

    // Front -> queue: classified commands. Samples outside the null threshold
    // and unknown kinds never enter the queue, so they cost the back end nothing.
    logic            push_valid;
    logic            push_ready;
    shl2d_pkg::cmd_t push_cmd;

    // Queue -> back
    logic            q_valid;
    logic            q_pop;
    shl2d_pkg::cmd_t q_cmd;

    // High while the store is being swept to zero (after reset or on a clear)
    logic            clearing;

    // Front: holds the threshold register, does the floor/clamp of both sample
    // axes or the read index clamp, and builds the flat bin address.
    shl2d_front #(
        .BINS_PER_AXIS (BINS_PER_AXIS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_x_value  (s_x_value),
        .s_y_value  (s_y_value),
        .s_read_row (s_read_row),
        .s_read_col (s_read_col),
        .clearing   (clearing),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    // Short command queue (QUEUE_DEPTH entries): the front keeps taking transfers, until
    // the queue is full, while the back is in a long read or while a result waits on m_ready.
    shl2d_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    // Back: bin store read-modify-write with saturation, largest count tracking,
    // clearing sweep, log10 readout and the registered output stage.
    shl2d_back #(
        .BINS_PER_AXIS (BINS_PER_AXIS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bin_count (m_bin_count),
        .m_bin_log   (m_bin_log),
        .m_max_log   (m_max_log),
        .m_scale_top (m_scale_top)
    );

endmodule

// ----- rtl/shl2d_checker.sv -----
module shl2d_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [31:0]                  m_bin_count,
    input logic [shl2d_pkg::LOG_W-1:0]  m_bin_log,
    input logic [shl2d_pkg::LOG_W-1:0]  m_max_log,
    input logic [shl2d_pkg::LOG_W-1:0]  m_scale_top
);

    // s_ready is low right after reset, when the store sweep begins
    a_reset_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    a_reset_drops_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high right after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bin_count) && $stable(m_scale_top))
        else $error("stalled result changed");

    a_small_count_log: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_bin_count <= 32'd1) |-> m_bin_log == '0)
        else $error("nonzero log for count of one or less");

    a_scale_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_max_log[11:0] < shl2d_pkg::HALF_Q12)
        |-> m_scale_top == {m_max_log[15:12], shl2d_pkg::HALF_Q12})
        else $error("scale top does not match max log");

endmodule

bind scatter_histogram_2d_log_core shl2d_checker u_shl2d_checker (.*);
